// ===== rtl/m3i_pkg.sv =====
// Shared types, widths and cofactor index tables for the 3x3 inverse block.
package m3i_pkg;

   localparam int ELEMS    = 9;
   localparam int ENT_W    = 32;   // Q16.16 entry
   localparam int PROD_W   = 64;   // cofactor, Q32.32
   localparam int DET_W    = 97;   // signed determinant, Q48.48
   localparam int MAG_W    = 96;   // determinant magnitude
   localparam int Q_BITS   = 32;   // quotient bits resolved by a divider lane
   localparam int IDX_W    = 4;

   localparam logic [ENT_W-1:0] DET_THRESHOLD_RESET = 32'd2814750;
   localparam logic [ENT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [ENT_W-1:0] SAT_NEG = 32'h8000_0000;

   // cofactor k = a[LA[k]]*a[LB[k]] - a[RA[k]]*a[RB[k]], k in row-major order
   localparam logic [IDX_W-1:0] CF_LA [ELEMS] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam logic [IDX_W-1:0] CF_LB [ELEMS] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam logic [IDX_W-1:0] CF_RA [ELEMS] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam logic [IDX_W-1:0] CF_RB [ELEMS] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

   typedef struct packed {
      logic signed [ENT_W-1:0] a00;
      logic signed [ENT_W-1:0] a01;
      logic signed [ENT_W-1:0] a02;
      logic signed [ENT_W-1:0] a10;
      logic signed [ENT_W-1:0] a11;
      logic signed [ENT_W-1:0] a12;
      logic signed [ENT_W-1:0] a20;
      logic signed [ENT_W-1:0] a21;
      logic signed [ENT_W-1:0] a22;
   } req_type;

   typedef struct packed {
      logic signed [ENT_W-1:0] b00;
      logic signed [ENT_W-1:0] b01;
      logic signed [ENT_W-1:0] b02;
      logic signed [ENT_W-1:0] b10;
      logic signed [ENT_W-1:0] b11;
      logic signed [ENT_W-1:0] b12;
      logic signed [ENT_W-1:0] b20;
      logic signed [ENT_W-1:0] b21;
      logic signed [ENT_W-1:0] b22;
      logic                    singular;
      logic                    saturated;
   } rsp_type;

endpackage

// ===== rtl/matrix3_inverse.sv =====
// Top level of the 3x3 fixed-point matrix inverse: cofactors, determinant, nine divider lanes.
//
//  channel   ports                          beat
//  --------  -----------------------------  ---------------------------------
//  request   req_valid/req_ready/req_data    one matrix, nine Q16.16 entries
//  response  rsp_valid/rsp_ready/rsp_data    inverse, singular and saturated
//  csr       csr_we/csr_wdata                det_threshold, 2^-48 units
//
//  One matrix enters per cycle while the response is not stalled; a result
//  passes the cofactor, determinant, divider lane and output register stages.
//  Most of the pipeline is the restoring divider lanes, which resolve one
//  quotient bit per stage.
//  Reset clears all valid bits and loads det_threshold with its default.
//  A stalled response holds every stage; req_ready follows rsp_ready then.
module matrix3_inverse (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  m3i_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output m3i_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);

   localparam int N = m3i_pkg::ELEMS;

   logic [31:0]        thr_ff;
   logic               en;
   logic               cf_vld, dt_vld, dneg, sing;
   logic signed [63:0] cof [N];
   logic signed [63:0] cof_d [N];
   logic signed [31:0] row0 [3];
   logic [95:0]        dmag;
   logic [N-1:0]       lane_vld, lane_sat, lane_zero;
   logic signed [31:0] lane_q [N];
   logic               rsp_valid_ff;
   m3i_pkg::rsp_type   rsp_ff, rsp_in;

   // advance the whole pipe whenever the output register can take a beat
   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= m3i_pkg::DET_THRESHOLD_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   m3i_cofactor u_cof (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .vld_in  (req_valid),
      .req     (req_data),
      .vld_out (cf_vld),
      .cof     (cof),
      .row0    (row0)
   );

   m3i_det u_det (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .vld_in    (cf_vld),
      .cof_in    (cof),
      .row0      (row0),
      .threshold (thr_ff),
      .vld_out   (dt_vld),
      .cof_out   (cof_d),
      .dmag      (dmag),
      .dneg      (dneg),
      .singular  (sing)
   );

   // one divider lane per inverse entry
   for (genvar k = 0; k < N; k++) begin : g_lane
      m3i_div_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .vld_in   (dt_vld),
         .cof      (cof_d[k]),
         .dmag     (dmag),
         .dneg     (dneg),
         .zero_in  (sing),
         .vld_out  (lane_vld[k]),
         .quot     (lane_q[k]),
         .sat      (lane_sat[k]),
         .zero_out (lane_zero[k])
      );
   end

   // merge: pack the lanes, fold the clip flags
   always_comb begin
      rsp_in.b00       = lane_q[0];
      rsp_in.b01       = lane_q[1];
      rsp_in.b02       = lane_q[2];
      rsp_in.b10       = lane_q[3];
      rsp_in.b11       = lane_q[4];
      rsp_in.b12       = lane_q[5];
      rsp_in.b20       = lane_q[6];
      rsp_in.b21       = lane_q[7];
      rsp_in.b22       = lane_q[8];
      rsp_in.singular  = lane_zero[0];
      rsp_in.saturated = |lane_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= &lane_vld;
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a singular beat carries no clip and zeros in b00, b01, b11, b12 and b22
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         !rsp_data.saturated && rsp_data.b00 == 0 && rsp_data.b11 == 0 &&
         rsp_data.b22 == 0 && rsp_data.b01 == 0 && rsp_data.b12 == 0)
      else $error("singular response with nonzero payload");

   // a clip flag needs at least one entry at a rail
   a_sat_rail : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         ((rsp_data.b00 == m3i_pkg::SAT_POS) || (rsp_data.b00 == m3i_pkg::SAT_NEG) ||
          (rsp_data.b01 == m3i_pkg::SAT_POS) || (rsp_data.b01 == m3i_pkg::SAT_NEG) ||
          (rsp_data.b02 == m3i_pkg::SAT_POS) || (rsp_data.b02 == m3i_pkg::SAT_NEG) ||
          (rsp_data.b10 == m3i_pkg::SAT_POS) || (rsp_data.b10 == m3i_pkg::SAT_NEG) ||
          (rsp_data.b11 == m3i_pkg::SAT_POS) || (rsp_data.b11 == m3i_pkg::SAT_NEG) ||
          (rsp_data.b12 == m3i_pkg::SAT_POS) || (rsp_data.b12 == m3i_pkg::SAT_NEG) ||
          (rsp_data.b20 == m3i_pkg::SAT_POS) || (rsp_data.b20 == m3i_pkg::SAT_NEG) ||
          (rsp_data.b21 == m3i_pkg::SAT_POS) || (rsp_data.b21 == m3i_pkg::SAT_NEG) ||
          (rsp_data.b22 == m3i_pkg::SAT_POS) || (rsp_data.b22 == m3i_pkg::SAT_NEG)))
      else $error("saturated flag without a clipped entry");

   // lanes run in lockstep: their valid bits always agree
   a_lane_lockstep : assert property (@(posedge clock) disable iff (reset)
      (lane_vld == '0) || (lane_vld == '1))
      else $error("divider lanes out of step");

endmodule

// ===== rtl/m3i_cofactor.sv =====
// Two-stage cofactor unit: eighteen 32x32 products, then nine differences.
module m3i_cofactor (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   vld_in,
   input  m3i_pkg::req_type       req,
   output logic                   vld_out,
   output logic signed [63:0]     cof [m3i_pkg::ELEMS],
   output logic signed [31:0]     row0 [3]
);

   logic signed [31:0] a [m3i_pkg::ELEMS];
   logic signed [63:0] pl_in [m3i_pkg::ELEMS];
   logic signed [63:0] pr_in [m3i_pkg::ELEMS];
   logic signed [63:0] pl_ff [m3i_pkg::ELEMS];
   logic signed [63:0] pr_ff [m3i_pkg::ELEMS];
   logic signed [63:0] cof_ff [m3i_pkg::ELEMS];
   logic signed [31:0] r0a_ff [3];
   logic signed [31:0] r0b_ff [3];
   logic [1:0]         vld_ff;

   assign a[0] = req.a00;
   assign a[1] = req.a01;
   assign a[2] = req.a02;
   assign a[3] = req.a10;
   assign a[4] = req.a11;
   assign a[5] = req.a12;
   assign a[6] = req.a20;
   assign a[7] = req.a21;
   assign a[8] = req.a22;

   always_comb begin
      for (int k = 0; k < m3i_pkg::ELEMS; k++) begin
         pl_in[k] = a[m3i_pkg::CF_LA[k]] * a[m3i_pkg::CF_LB[k]];
         pr_in[k] = a[m3i_pkg::CF_RA[k]] * a[m3i_pkg::CF_RB[k]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[0], vld_in};
      end
      if (en) begin
         for (int k = 0; k < m3i_pkg::ELEMS; k++) begin
            pl_ff[k]  <= pl_in[k];
            pr_ff[k]  <= pr_in[k];
            cof_ff[k] <= pl_ff[k] - pr_ff[k];
         end
         for (int j = 0; j < 3; j++) begin
            r0a_ff[j] <= a[j];
            r0b_ff[j] <= r0a_ff[j];
         end
      end
   end

   assign vld_out = vld_ff[1];
   assign cof     = cof_ff;
   assign row0    = r0b_ff;

endmodule

// ===== rtl/m3i_det.sv =====
// Determinant path: split partial products, terms, sum, magnitude and singular test.
module m3i_det (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   vld_in,
   input  logic signed [63:0]     cof_in [m3i_pkg::ELEMS],
   input  logic signed [31:0]     row0 [3],
   input  logic [31:0]            threshold,
   output logic                   vld_out,
   output logic signed [63:0]     cof_out [m3i_pkg::ELEMS],
   output logic [95:0]            dmag,
   output logic                   dneg,
   output logic                   singular
);

   localparam int DW = m3i_pkg::DET_W;
   localparam int MW = m3i_pkg::MAG_W;
   localparam int DEPTH = 4;

   logic signed [63:0] cq_ff [DEPTH][m3i_pkg::ELEMS];
   logic signed [63:0] ph_ff [3];
   logic signed [64:0] pl_ff [3];
   logic signed [DW-1:0] t_ff [3];
   logic signed [DW-1:0] det_ff;
   logic [MW-1:0]      dmag_ff;
   logic               dneg_ff;
   logic               sing_ff;
   logic [DEPTH-1:0]   vld_ff;
   logic signed [63:0] ph_in [3];
   logic signed [64:0] pl_in [3];
   logic signed [DW-1:0] t_in [3];
   logic signed [DW-1:0] mag_in;
   logic signed [63:0] cpick [3];

   assign cpick[0] = cof_in[0];
   assign cpick[1] = cof_in[3];
   assign cpick[2] = cof_in[6];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ph_in[j] = row0[j] * $signed(cpick[j][63:32]);
         pl_in[j] = row0[j] * $signed({1'b0, cpick[j][31:0]});
         t_in[j]  = (DW'(ph_ff[j]) <<< 32) + DW'(pl_ff[j]);
      end
      mag_in = det_ff[DW-1] ? -det_ff : det_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], vld_in};
      end
      if (en) begin
         cq_ff[0] <= cof_in;
         for (int s = 1; s < DEPTH; s++) begin
            cq_ff[s] <= cq_ff[s-1];
         end
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         t_ff    <= t_in;
         det_ff  <= t_ff[0] + t_ff[1] + t_ff[2];
         dneg_ff <= det_ff[DW-1];
         dmag_ff <= mag_in[MW-1:0];
         // zero is always singular, also with a zero bound
         sing_ff <= (mag_in[MW-1:0] == '0) ||
                    (mag_in[MW-1:0] < {{(MW-32){1'b0}}, threshold});
      end
   end

   assign vld_out  = vld_ff[DEPTH-1];
   assign cof_out  = cq_ff[DEPTH-1];
   assign dmag     = dmag_ff;
   assign dneg     = dneg_ff;
   assign singular = sing_ff;

endmodule

// ===== rtl/m3i_div_lane.sv =====
// One divider lane: cofactor over determinant, one quotient bit per stage, then sign and clip.
module m3i_div_lane (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               vld_in,
   input  logic signed [63:0] cof,
   input  logic [95:0]        dmag,
   input  logic               dneg,
   input  logic               zero_in,
   output logic               vld_out,
   output logic signed [31:0] quot,
   output logic               sat,
   output logic               zero_out
);

   localparam int QB = m3i_pkg::Q_BITS;
   localparam int MW = m3i_pkg::MAG_W;

   logic [MW-1:0] rem_ff [QB+1];
   logic [MW-1:0] dm_ff  [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic          neg_ff [QB+1];
   logic          pre_ff [QB+1];
   logic          zr_ff  [QB+1];
   logic          vld_ff [QB+1];
   logic [63:0]   cm_in;
   logic [QB-1:0] q_last;
   logic signed [31:0] quot_ff, quot_in;
   logic          sat_ff, sat_in, zout_ff, vout_ff;

   assign cm_in = cof[63] ? 64'(-cof) : cof;

   // cm >= dmag means the quotient reaches 2^32: clip without dividing
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_in;
      end
      if (en) begin
         rem_ff[0] <= {{(MW-64){1'b0}}, cm_in};
         dm_ff[0]  <= dmag;
         q_ff[0]   <= '0;
         neg_ff[0] <= cof[63] ^ dneg;
         pre_ff[0] <= {{(MW-64){1'b0}}, cm_in} >= dmag;
         zr_ff[0]  <= zero_in;
      end
   end

   for (genvar i = 1; i <= QB; i++) begin : g_step
      logic [MW:0]   two;
      logic          ge;
      logic [MW-1:0] rem_in;
      assign two    = {rem_ff[i-1], 1'b0};
      assign ge     = two >= {1'b0, dm_ff[i-1]};
      assign rem_in = ge ? MW'(two - {1'b0, dm_ff[i-1]}) : two[MW-1:0];
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         if (en) begin
            rem_ff[i] <= rem_in;
            dm_ff[i]  <= dm_ff[i-1];
            q_ff[i]   <= {q_ff[i-1][QB-2:0], ge};
            neg_ff[i] <= neg_ff[i-1];
            pre_ff[i] <= pre_ff[i-1];
            zr_ff[i]  <= zr_ff[i-1];
         end
      end
   end

   assign q_last = q_ff[QB];

   always_comb begin
      quot_in = '0;
      sat_in  = 1'b0;
      if (zr_ff[QB]) begin
         quot_in = '0;
         sat_in  = 1'b0;
      end else if (neg_ff[QB]) begin
         if (pre_ff[QB] || q_last > m3i_pkg::SAT_NEG) begin
            quot_in = m3i_pkg::SAT_NEG;
            sat_in  = 1'b1;
         end else begin
            quot_in = -$signed(q_last);
         end
      end else begin
         if (pre_ff[QB] || q_last[QB-1]) begin
            quot_in = m3i_pkg::SAT_POS;
            sat_in  = 1'b1;
         end else begin
            quot_in = $signed(q_last);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en) begin
         vout_ff <= vld_ff[QB];
      end
      if (en) begin
         quot_ff <= quot_in;
         sat_ff  <= sat_in;
         zout_ff <= zr_ff[QB];
      end
   end

   assign vld_out  = vout_ff;
   assign quot     = quot_ff;
   assign sat      = sat_ff;
   assign zero_out = zout_ff;

endmodule

// ===== tb/sv/matrix3_inverse_tb.sv =====
// Self-checking testbench for the 3x3 fixed-point matrix inverse block.
module matrix3_inverse_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY    = 41;
   localparam int STALL_MAX  = 17;
   localparam int DOG_LIMIT  = 4000;
   localparam int RAND_ITEMS = 1040;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   m3i_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   m3i_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   matrix3_inverse dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: the threshold as the block should hold it.
   logic [31:0] threshold_shadow = m3i_pkg::DET_THRESHOLD_RESET;
   m3i_pkg::rsp_type inverse_queue[$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          stim_done = 0;
   bit          hold_off_req = 0;   // sender asks receiver for a long stall

   // Compute the inverse: exact cofactors, exact determinant, truncated divide.
   function automatic m3i_pkg::rsp_type invert(m3i_pkg::req_type m, logic [31:0] thr);
      m3i_pkg::rsp_type r;
      logic signed [63:0] a[9];
      logic signed [63:0] cf[9];
      logic signed [127:0] det;
      logic [127:0] dmag, num, q, cmag;
      logic neg;
      r = '0;
      a[0] = m.a00; a[1] = m.a01; a[2] = m.a02;
      a[3] = m.a10; a[4] = m.a11; a[5] = m.a12;
      a[6] = m.a20; a[7] = m.a21; a[8] = m.a22;
      cf[0] = a[4]*a[8] - a[5]*a[7];
      cf[1] = a[2]*a[7] - a[1]*a[8];
      cf[2] = a[1]*a[5] - a[2]*a[4];
      cf[3] = a[5]*a[6] - a[3]*a[8];
      cf[4] = a[0]*a[8] - a[2]*a[6];
      cf[5] = a[2]*a[3] - a[0]*a[5];
      cf[6] = a[3]*a[7] - a[4]*a[6];
      cf[7] = a[1]*a[6] - a[0]*a[7];
      cf[8] = a[0]*a[4] - a[1]*a[3];
      det = 128'(a[0]) * 128'(cf[0]) + 128'(a[1]) * 128'(cf[3])
          + 128'(a[2]) * 128'(cf[6]);
      dmag = det[127] ? -det : det;
      if (dmag == 0 || dmag < {96'd0, thr}) begin
         r.singular = 1'b1;
         return r;
      end
      for (int k = 0; k < 9; k++) begin
         cmag = cf[k][63] ? 128'(-cf[k]) & 128'hFFFF_FFFF_FFFF_FFFF
                          : 128'(cf[k]);
         num = cmag << 32;
         q = num / dmag;
         neg = cf[k][63] ^ det[127];
         if (neg) begin
            if (q > 128'h8000_0000) begin
               cf[k] = 64'(m3i_pkg::SAT_NEG); r.saturated = 1'b1;
            end else cf[k] = 64'(-q);
         end else begin
            if (q > 128'h7FFF_FFFF) begin
               cf[k] = 64'(m3i_pkg::SAT_POS); r.saturated = 1'b1;
            end else cf[k] = 64'(q);
         end
      end
      r.b00 = cf[0][31:0]; r.b01 = cf[1][31:0]; r.b02 = cf[2][31:0];
      r.b10 = cf[3][31:0]; r.b11 = cf[4][31:0]; r.b12 = cf[5][31:0];
      r.b20 = cf[6][31:0]; r.b21 = cf[7][31:0]; r.b22 = cf[8][31:0];
      return r;
   endfunction

   // Drive one matrix from a falling edge, wait for the beat; queue the
   // expectation at the accepting edge. Valid stays up when no gap follows.
   task automatic send_matrix(m3i_pkg::req_type m, int gap, bit typed = 1'b0,
                              m3i_pkg::rsp_type typed_r = '0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= m;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (typed) inverse_queue.push_back(typed_r);
      else inverse_queue.push_back(invert(m, threshold_shadow));
      @(negedge clock);
   endtask

   // Write the threshold only once the pipe has drained.
   task automatic write_threshold(logic [31:0] v);
      req_valid <= 1'b0;
      wait (inverse_queue.size() == 0);
      repeat (LATENCY + 4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      threshold_shadow = v;
   endtask

   function automatic logic [31:0] rand_entry();
      unique case ($urandom_range(0, 5))
         0: return $urandom;                                  // full range
         1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         2: return 32'($signed($urandom_range(0, 511)) - 256);
         3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   function automatic m3i_pkg::req_type rand_matrix();
      m3i_pkg::req_type m;
      m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
           rand_entry(), rand_entry(), rand_entry(), rand_entry()};
      // advance toward near-singular cases: copy one row onto another
      if ($urandom_range(0, 7) == 0) begin
         m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
         if ($urandom_range(0, 1)) m.a22 = m.a22 + 1;
      end
      return m;
   endfunction

   // Directed table: identity, scaled identity, singular, extremes.
   // Rows with an obvious answer carry it; the rest go through the predictor.
   localparam int N_DIR = 10;
   m3i_pkg::req_type dir_table[N_DIR];
   m3i_pkg::rsp_type dir_exp[N_DIR];
   bit               dir_typed[N_DIR];
   initial begin
      localparam logic [31:0] ONE = 32'h0001_0000;
      for (int i = 0; i < N_DIR; i++) begin
         dir_exp[i]   = '0;
         dir_typed[i] = 1'b0;
      end
      dir_table[0] = {ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE};
      dir_table[1] = '0;                                  // zero determinant
      dir_table[2] = {9{ONE}};                            // rank one
      dir_table[3] = {32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1};
      dir_table[4] = {32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'd0,
                      32'd0, 32'd0, 32'h8000_0000};
      dir_table[5] = {32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0,
                      32'd0, 32'd0, 32'h7FFF_FFFF};
      dir_table[6] = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000};
      dir_table[7] = {32'd256, 32'd0, 32'd0, 32'd0, 32'd256, 32'd0, 32'd0, 32'd0, 32'd256};
      dir_table[8] = {32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0,
                      32'd0, 32'd0, 32'hFFFF_FFFF};       // saturates negative at a zero threshold
      dir_table[9] = {32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0002_0000};
      // identity inverts to itself at every threshold
      dir_typed[0]   = 1'b1;
      dir_exp[0].b00 = ONE;
      dir_exp[0].b11 = ONE;
      dir_exp[0].b22 = ONE;
      // zero and rank-one matrices are always singular
      dir_typed[1]        = 1'b1;
      dir_exp[1].singular = 1'b1;
      dir_typed[2]        = 1'b1;
      dir_exp[2].singular = 1'b1;
   end

   // Stimulus process.
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed rows at the reset threshold, then at both extremes
      for (int pass = 0; pass < 3; pass++) begin
         if (pass == 1) write_threshold(32'd0);
         if (pass == 2) write_threshold(32'hFFFF_FFFF);
         for (int i = 0; i < N_DIR; i++)
            send_matrix(dir_table[i], $urandom_range(0, 2), dir_typed[i], dir_exp[i]);
      end
      write_threshold(m3i_pkg::DET_THRESHOLD_RESET);
      // burst against a stalled receiver: fill the pipe until input stalls
      hold_off_req = 1;
      for (int i = 0; i < 80; i++) send_matrix(rand_matrix(), 0);
      hold_off_req = 0;
      req_valid <= 1'b0;
      // pause the sender until every result has come back
      wait (inverse_queue.size() == 0);
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i % 300 == 299)
            write_threshold(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1 << 24));
         send_matrix(rand_matrix(), ($urandom_range(0, 3) == 0) ? 0
                                                : $urandom_range(0, STALL_MAX));
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // Receiver: random stalls, one long hold-off while the sender streams.
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            n = 0;
            while (n < 120) begin
               @(negedge clock);
               n++;
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
         if (n != 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   // Check each result beat against the oldest expectation.
   always @(posedge clock) begin
      m3i_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (inverse_queue.size() == 0) begin
            $error("result beat with no expectation waiting");
            errors++;
         end else begin
            exp_r = inverse_queue.pop_front();
            if (rsp_data.b00 !== exp_r.b00) begin $error("b00 exp %h got %h", exp_r.b00, rsp_data.b00); errors++; end
            if (rsp_data.b01 !== exp_r.b01) begin $error("b01 exp %h got %h", exp_r.b01, rsp_data.b01); errors++; end
            if (rsp_data.b02 !== exp_r.b02) begin $error("b02 exp %h got %h", exp_r.b02, rsp_data.b02); errors++; end
            if (rsp_data.b10 !== exp_r.b10) begin $error("b10 exp %h got %h", exp_r.b10, rsp_data.b10); errors++; end
            if (rsp_data.b11 !== exp_r.b11) begin $error("b11 exp %h got %h", exp_r.b11, rsp_data.b11); errors++; end
            if (rsp_data.b12 !== exp_r.b12) begin $error("b12 exp %h got %h", exp_r.b12, rsp_data.b12); errors++; end
            if (rsp_data.b20 !== exp_r.b20) begin $error("b20 exp %h got %h", exp_r.b20, rsp_data.b20); errors++; end
            if (rsp_data.b21 !== exp_r.b21) begin $error("b21 exp %h got %h", exp_r.b21, rsp_data.b21); errors++; end
            if (rsp_data.b22 !== exp_r.b22) begin $error("b22 exp %h got %h", exp_r.b22, rsp_data.b22); errors++; end
            if (rsp_data.singular !== exp_r.singular) begin
               $error("singular exp %b got %b", exp_r.singular, rsp_data.singular); errors++;
            end
            if (rsp_data.saturated !== exp_r.saturated) begin
               $error("saturated exp %b got %b", exp_r.saturated, rsp_data.saturated); errors++;
            end
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > DOG_LIMIT) begin
         $display("FAIL matrix3_inverse");
         $finish;
      end
   end

   // End of run: drain, then let the latency pass for stray beats.
   initial begin
      wait (stim_done);
      wait (inverse_queue.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0 && inverse_queue.size() == 0)
         $display("PASS matrix3_inverse");
      else
         $display("FAIL matrix3_inverse");
      $finish;
   end

endmodule
